// ===== design/shbe_pkg.sv =====
`timescale 1ns / 1ps

package shbe_pkg;

    localparam int SYMBOLS_DEF  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int COUNT_BITS   = 20;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 28;
    localparam int BITS_W   = 26;
    localparam int TOTAL_W  = 9;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;

    localparam logic [NODE_W-1:0]   NO_NODE    = 10'h3FF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 28'hFFFFFFF;
    localparam logic [BITS_W-1:0]   BITS_MAX   = 26'h3FFFFFF;

    typedef enum logic [2:0] {
        CMD_TALLY  = 3'd0,
        CMD_BUILD  = 3'd1,
        CMD_ENCODE = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TOTAL = 2'd1,
        KIND_BUILD = 2'd2,
        KIND_ENTRY = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TALLY_LOOK,
        ST_TALLY_INC,
        ST_ENC_LOOK,
        ST_ENC_LOAD,
        ST_ENC_BIT,
        ST_FLUSH_BYTE,
        ST_FLUSH_TOTAL,
        ST_READ,
        ST_CLEAR,
        ST_INIT,
        ST_SCAN,
        ST_MERGE1,
        ST_MERGE2,
        ST_CODE_START,
        ST_CODE_STEP,
        ST_CODE_PAR,
        ST_CODE_WRITE,
        ST_BLD_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_TALLY_LOOK,
        OP_TALLY_INC,
        OP_ENC_LOOK,
        OP_ENC_LOAD,
        OP_ENC_BIT,
        OP_FLUSH_BYTE,
        OP_FLUSH_TOTAL,
        OP_READ,
        OP_CLEAR,
        OP_INIT,
        OP_SCAN,
        OP_MERGE1,
        OP_MERGE2,
        OP_CODE_START,
        OP_CODE_STEP,
        OP_CODE_PAR,
        OP_CODE_WRITE,
        OP_BLD_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctl;

    typedef struct packed {
        logic hit;
        logic fill_nz;
        logic enc_go;
        logic enc_end;
        logic init_end;
        logic total_zero;
        logic total_gt1;
        logic scan_done;
        logic live_gt2;
        logic at_root;
        logic len_over;
        logic code_end;
    } t_sts;

endpackage

// ===== design/shbe_ram.sv =====
`timescale 1ns / 1ps

module shbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/shbe_ctrl.sv =====
`timescale 1ns / 1ps

module shbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_command,
    input  shbe_pkg::t_sts  i_sts,
    output shbe_pkg::t_ctl  o_ctl,
    output logic            o_busy
);

    shbe_pkg::t_state r_state;
    shbe_pkg::t_state n_state;
    shbe_pkg::t_cmd   cmd;

    assign cmd = shbe_pkg::t_cmd'(i_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shbe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            shbe_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (cmd)
                        shbe_pkg::CMD_TALLY:  n_state = shbe_pkg::ST_TALLY_LOOK;
                        shbe_pkg::CMD_BUILD:  n_state = i_sts.total_zero ?
                                                  shbe_pkg::ST_BLD_DONE : shbe_pkg::ST_INIT;
                        shbe_pkg::CMD_ENCODE: n_state = shbe_pkg::ST_ENC_LOOK;
                        shbe_pkg::CMD_FLUSH:  n_state = i_sts.fill_nz ?
                                                  shbe_pkg::ST_FLUSH_BYTE :
                                                  shbe_pkg::ST_FLUSH_TOTAL;
                        shbe_pkg::CMD_READ:   n_state = shbe_pkg::ST_READ;
                        shbe_pkg::CMD_CLEAR:  n_state = shbe_pkg::ST_CLEAR;
                        default:              n_state = shbe_pkg::ST_IDLE;
                    endcase
                end
            end
            shbe_pkg::ST_TALLY_LOOK: begin
                n_state = i_sts.hit ? shbe_pkg::ST_TALLY_INC : shbe_pkg::ST_IDLE;
            end
            shbe_pkg::ST_TALLY_INC:  n_state = shbe_pkg::ST_IDLE;
            shbe_pkg::ST_ENC_LOOK: begin
                n_state = i_sts.hit ? shbe_pkg::ST_ENC_LOAD : shbe_pkg::ST_IDLE;
            end
            shbe_pkg::ST_ENC_LOAD: begin
                n_state = i_sts.enc_go ? shbe_pkg::ST_ENC_BIT : shbe_pkg::ST_IDLE;
            end
            shbe_pkg::ST_ENC_BIT: begin
                n_state = i_sts.enc_end ? shbe_pkg::ST_IDLE : shbe_pkg::ST_ENC_BIT;
            end
            shbe_pkg::ST_FLUSH_BYTE:  n_state = shbe_pkg::ST_FLUSH_TOTAL;
            shbe_pkg::ST_FLUSH_TOTAL: n_state = shbe_pkg::ST_IDLE;
            shbe_pkg::ST_READ:        n_state = shbe_pkg::ST_IDLE;
            shbe_pkg::ST_CLEAR:       n_state = shbe_pkg::ST_IDLE;
            shbe_pkg::ST_INIT: begin
                if (i_sts.init_end) begin
                    n_state = i_sts.total_gt1 ? shbe_pkg::ST_SCAN : shbe_pkg::ST_CODE_START;
                end
            end
            shbe_pkg::ST_SCAN: begin
                n_state = i_sts.scan_done ? shbe_pkg::ST_MERGE1 : shbe_pkg::ST_SCAN;
            end
            shbe_pkg::ST_MERGE1: n_state = shbe_pkg::ST_MERGE2;
            shbe_pkg::ST_MERGE2: begin
                n_state = i_sts.live_gt2 ? shbe_pkg::ST_SCAN : shbe_pkg::ST_CODE_START;
            end
            shbe_pkg::ST_CODE_START: n_state = shbe_pkg::ST_CODE_STEP;
            shbe_pkg::ST_CODE_STEP: begin
                if (i_sts.len_over) begin
                    n_state = shbe_pkg::ST_BLD_DONE;
                end else if (i_sts.at_root) begin
                    n_state = shbe_pkg::ST_CODE_WRITE;
                end else begin
                    n_state = shbe_pkg::ST_CODE_PAR;
                end
            end
            shbe_pkg::ST_CODE_PAR: n_state = shbe_pkg::ST_CODE_STEP;
            shbe_pkg::ST_CODE_WRITE: begin
                n_state = i_sts.code_end ? shbe_pkg::ST_BLD_DONE : shbe_pkg::ST_CODE_START;
            end
            shbe_pkg::ST_BLD_DONE: n_state = shbe_pkg::ST_IDLE;
            default:               n_state = shbe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = (r_state != shbe_pkg::ST_IDLE);
        o_ctl.accept = i_start && (r_state == shbe_pkg::ST_IDLE);
        case (r_state)
            shbe_pkg::ST_IDLE:        o_ctl.op = shbe_pkg::OP_IDLE;
            shbe_pkg::ST_TALLY_LOOK:  o_ctl.op = shbe_pkg::OP_TALLY_LOOK;
            shbe_pkg::ST_TALLY_INC:   o_ctl.op = shbe_pkg::OP_TALLY_INC;
            shbe_pkg::ST_ENC_LOOK:    o_ctl.op = shbe_pkg::OP_ENC_LOOK;
            shbe_pkg::ST_ENC_LOAD:    o_ctl.op = shbe_pkg::OP_ENC_LOAD;
            shbe_pkg::ST_ENC_BIT:     o_ctl.op = shbe_pkg::OP_ENC_BIT;
            shbe_pkg::ST_FLUSH_BYTE:  o_ctl.op = shbe_pkg::OP_FLUSH_BYTE;
            shbe_pkg::ST_FLUSH_TOTAL: o_ctl.op = shbe_pkg::OP_FLUSH_TOTAL;
            shbe_pkg::ST_READ:        o_ctl.op = shbe_pkg::OP_READ;
            shbe_pkg::ST_CLEAR:       o_ctl.op = shbe_pkg::OP_CLEAR;
            shbe_pkg::ST_INIT:        o_ctl.op = shbe_pkg::OP_INIT;
            shbe_pkg::ST_SCAN:        o_ctl.op = shbe_pkg::OP_SCAN;
            shbe_pkg::ST_MERGE1:      o_ctl.op = shbe_pkg::OP_MERGE1;
            shbe_pkg::ST_MERGE2:      o_ctl.op = shbe_pkg::OP_MERGE2;
            shbe_pkg::ST_CODE_START:  o_ctl.op = shbe_pkg::OP_CODE_START;
            shbe_pkg::ST_CODE_STEP:   o_ctl.op = shbe_pkg::OP_CODE_STEP;
            shbe_pkg::ST_CODE_PAR:    o_ctl.op = shbe_pkg::OP_CODE_PAR;
            shbe_pkg::ST_CODE_WRITE:  o_ctl.op = shbe_pkg::OP_CODE_WRITE;
            shbe_pkg::ST_BLD_DONE:    o_ctl.op = shbe_pkg::OP_BLD_DONE;
            default:                  o_ctl.op = shbe_pkg::OP_IDLE;
        endcase
    end

endmodule

// ===== design/shbe_dp.sv =====
`timescale 1ns / 1ps

module shbe_dp #(
    parameter int SYMBOLS = shbe_pkg::SYMBOLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  shbe_pkg::t_ctl  i_ctl,
    output shbe_pkg::t_sts  o_sts,
    input  logic [2:0]      i_command,
    input  logic [7:0]      i_data_byte,
    input  logic [7:0]      i_slot_index,
    output logic            o_strobe,
    output logic [1:0]      o_result_kind,
    output logic [7:0]      o_out_byte,
    output logic [25:0]     o_total_bits,
    output logic [8:0]      o_distinct_symbols,
    output logic [7:0]      o_symbol,
    output logic [5:0]      o_code_nbits,
    output logic [31:0]     o_code_bits,
    output logic            o_entry_valid,
    output logic            o_last
);

    localparam int SLOT_AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int NODE_AW = $clog2(2 * SYMBOLS);
    localparam logic [8:0] SYM_COUNT = 9'(SYMBOLS);
    localparam logic [9:0] NODE_BASE = 10'(SYMBOLS);
    localparam logic [27:0] CMAX = 28'((1 << shbe_pkg::COUNT_BITS) - 1);
    localparam logic [5:0] LEN_LIMIT = 6'(shbe_pkg::MAX_CODE_LEN);

    shbe_pkg::t_op op;

    logic [255:0]        r_vld;
    logic [7:0]          r_byte;
    logic [7:0]          r_si;
    logic [SLOT_AW-1:0]  r_slot;
    logic [8:0]          r_total;
    logic [7:0]          r_pack;
    logic [2:0]          r_fill;
    logic [25:0]         r_bits;
    logic                r_nocodes;
    logic [5:0]          r_rem;
    logic [31:0]         r_code;
    logic [8:0]          r_s;
    logic [8:0]          r_live;
    logic [8:0]          r_k;
    logic [9:0]          r_root;
    logic                r_p1;
    logic                r_p2;
    logic [SLOT_AW-1:0]  r_s1;
    logic [SLOT_AW-1:0]  r_s2;
    logic [9:0]          r_nd2;
    logic                r_f1;
    logic                r_f2;
    logic [27:0]         r_w1;
    logic [27:0]         r_w2;
    logic [SLOT_AW-1:0]  r_a;
    logic [SLOT_AW-1:0]  r_b;
    logic [9:0]          r_na;
    logic [9:0]          r_nb;
    logic [9:0]          r_nd;
    logic [5:0]          r_len;
    logic [31:0]         r_cw;

    logic                r_strobe;
    shbe_pkg::t_kind     r_kind;
    logic [7:0]          r_obyte;
    logic [25:0]         r_obits;
    logic [8:0]          r_odist;
    logic [7:0]          r_osym;
    logic [5:0]          r_olen;
    logic [31:0]         r_ocode;
    logic                r_oval;
    logic                r_olast;

    logic                sos_we;
    logic [SLOT_AW-1:0]  sos_rd;
    logic                sym_we;
    logic [7:0]          sym_rd;
    logic                wt_we;
    logic [NODE_AW-1:0]  wt_wa;
    logic [27:0]         wt_wd;
    logic [NODE_AW-1:0]  wt_ra;
    logic [27:0]         wt_rd;
    logic                par_we;
    logic [NODE_AW-1:0]  par_wa;
    logic [9:0]          par_wd;
    logic [9:0]          par_rd;
    logic                act_we;
    logic [SLOT_AW-1:0]  act_wa;
    logic [9:0]          act_wd;
    logic [9:0]          act_rd;
    logic                tbl_we;
    logic [SLOT_AW-1:0]  tbl_wa;
    logic [5:0]          len_wd;
    logic [31:0]         code_wd;
    logic [SLOT_AW-1:0]  tbl_ra;
    logic [5:0]          len_rd;
    logic [31:0]         code_rd;

    logic                hit;
    logic                room;
    logic                new_sym;
    logic [9:0]          nn;
    logic [28:0]         sum;
    logic [27:0]         merged;
    logic [5:0]          rem_m1;
    logic                bitv;
    logic [7:0]          pack_or;
    logic [25:0]         n_bits;
    logic                read_hit;
    logic [5:0]          read_len;

    logic                e_strobe;
    shbe_pkg::t_kind     e_kind;
    logic [7:0]          e_byte;
    logic [7:0]          e_sym;
    logic [5:0]          e_len;
    logic [31:0]         e_code;
    logic                e_val;
    logic                e_last;

    assign op       = i_ctl.op;
    assign hit      = r_vld[r_byte];
    assign room     = (r_total < SYM_COUNT);
    assign new_sym  = !hit && room;
    assign nn       = NODE_BASE + 10'(r_k);
    assign sum      = {1'b0, r_w1} + {1'b0, r_w2};
    assign merged   = sum[28] ? shbe_pkg::WEIGHT_MAX : sum[27:0];
    assign rem_m1   = r_rem - 6'd1;
    assign bitv     = r_code[rem_m1[4:0]];
    assign pack_or  = r_pack | (8'(bitv) << (3'd7 - r_fill));
    assign n_bits   = (r_bits != shbe_pkg::BITS_MAX) ? r_bits + 26'd1 : r_bits;
    assign read_hit = ({1'b0, r_si} < r_total);
    assign read_len = r_nocodes ? 6'd0 : len_rd;

    assign o_sts.hit        = hit;
    assign o_sts.fill_nz    = (r_fill != 3'd0);
    assign o_sts.enc_go     = !r_nocodes && (len_rd != 6'd0);
    assign o_sts.enc_end    = (r_rem == 6'd1);
    assign o_sts.init_end   = (r_s == r_total - 9'd1);
    assign o_sts.total_zero = (r_total == 9'd0);
    assign o_sts.total_gt1  = (r_total > 9'd1);
    assign o_sts.scan_done  = (r_s == r_total) && !r_p1 && !r_p2;
    assign o_sts.live_gt2   = (r_live > 9'd2);
    assign o_sts.at_root    = (r_nd == r_root);
    assign o_sts.len_over   = (r_len > LEN_LIMIT);
    assign o_sts.code_end   = (r_s == r_total - 9'd1);

    shbe_ram #(.WIDTH(SLOT_AW), .DEPTH(256)) u_sos (
        .i_clk(i_clk), .i_we(sos_we), .i_waddr(r_byte), .i_wdata(r_total[SLOT_AW-1:0]),
        .i_raddr(i_data_byte), .o_rdata(sos_rd)
    );

    shbe_ram #(.WIDTH(8), .DEPTH(SYMBOLS)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(r_total[SLOT_AW-1:0]), .i_wdata(r_byte),
        .i_raddr(i_slot_index[SLOT_AW-1:0]), .o_rdata(sym_rd)
    );

    shbe_ram #(.WIDTH(28), .DEPTH(2 * SYMBOLS)) u_wt (
        .i_clk(i_clk), .i_we(wt_we), .i_waddr(wt_wa), .i_wdata(wt_wd),
        .i_raddr(wt_ra), .o_rdata(wt_rd)
    );

    shbe_ram #(.WIDTH(10), .DEPTH(2 * SYMBOLS)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(r_nd[NODE_AW-1:0]), .o_rdata(par_rd)
    );

    shbe_ram #(.WIDTH(10), .DEPTH(SYMBOLS)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_wa), .i_wdata(act_wd),
        .i_raddr(r_s[SLOT_AW-1:0]), .o_rdata(act_rd)
    );

    shbe_ram #(.WIDTH(6), .DEPTH(SYMBOLS)) u_len (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(tbl_wa), .i_wdata(len_wd),
        .i_raddr(tbl_ra), .o_rdata(len_rd)
    );

    shbe_ram #(.WIDTH(32), .DEPTH(SYMBOLS)) u_code (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(tbl_wa), .i_wdata(code_wd),
        .i_raddr(tbl_ra), .o_rdata(code_rd)
    );

    always_comb begin
        sos_we  = 1'b0;
        sym_we  = 1'b0;
        wt_we   = 1'b0;
        wt_wa   = NODE_AW'(r_total[SLOT_AW-1:0]);
        wt_wd   = 28'd1;
        par_we  = 1'b0;
        par_wa  = r_na[NODE_AW-1:0];
        par_wd  = {nn[8:0], 1'b0};
        act_we  = 1'b0;
        act_wa  = r_s[SLOT_AW-1:0];
        act_wd  = 10'(r_s);
        tbl_we  = 1'b0;
        tbl_wa  = r_s[SLOT_AW-1:0];
        len_wd  = r_len;
        code_wd = r_cw;
        tbl_ra  = (op == shbe_pkg::OP_ENC_LOOK) ? sos_rd : i_slot_index[SLOT_AW-1:0];
        wt_ra   = (op == shbe_pkg::OP_SCAN) ? act_rd[NODE_AW-1:0] : NODE_AW'(sos_rd);
        case (op)
            shbe_pkg::OP_TALLY_LOOK: begin
                if (new_sym) begin
                    sos_we  = 1'b1;
                    sym_we  = 1'b1;
                    wt_we   = 1'b1;
                    tbl_we  = 1'b1;
                    tbl_wa  = r_total[SLOT_AW-1:0];
                    len_wd  = 6'd0;
                    code_wd = 32'd0;
                end
            end
            shbe_pkg::OP_TALLY_INC: begin
                wt_we = (wt_rd < CMAX);
                wt_wa = NODE_AW'(r_slot);
                wt_wd = wt_rd + 28'd1;
            end
            shbe_pkg::OP_INIT: begin
                act_we = 1'b1;
            end
            shbe_pkg::OP_MERGE1: begin
                wt_we  = 1'b1;
                wt_wa  = nn[NODE_AW-1:0];
                wt_wd  = merged;
                par_we = 1'b1;
                act_we = 1'b1;
                act_wa = r_a;
                act_wd = nn;
            end
            shbe_pkg::OP_MERGE2: begin
                par_we = 1'b1;
                par_wa = r_nb[NODE_AW-1:0];
                par_wd = {nn[8:0], 1'b1};
                act_we = 1'b1;
                act_wa = r_b;
                act_wd = shbe_pkg::NO_NODE;
            end
            shbe_pkg::OP_CODE_WRITE: begin
                tbl_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        e_strobe = 1'b0;
        e_kind   = shbe_pkg::KIND_BYTE;
        e_byte   = 8'd0;
        e_sym    = 8'd0;
        e_len    = 6'd0;
        e_code   = 32'd0;
        e_val    = 1'b0;
        e_last   = 1'b0;
        case (op)
            shbe_pkg::OP_ENC_BIT: begin
                if (r_fill == 3'd7) begin
                    e_strobe = 1'b1;
                    e_byte   = pack_or;
                    e_last   = (rem_m1 < 6'd8);
                end
            end
            shbe_pkg::OP_FLUSH_BYTE: begin
                e_strobe = 1'b1;
                e_byte   = r_pack;
            end
            shbe_pkg::OP_FLUSH_TOTAL: begin
                e_strobe = 1'b1;
                e_kind   = shbe_pkg::KIND_TOTAL;
                e_last   = 1'b1;
            end
            shbe_pkg::OP_READ: begin
                e_strobe = 1'b1;
                e_kind   = shbe_pkg::KIND_ENTRY;
                e_last   = 1'b1;
                if (read_hit) begin
                    e_val  = 1'b1;
                    e_sym  = sym_rd;
                    e_len  = read_len;
                    e_code = (read_len != 6'd0) ? code_rd : 32'd0;
                end
            end
            shbe_pkg::OP_BLD_DONE: begin
                e_strobe = 1'b1;
                e_kind   = shbe_pkg::KIND_BUILD;
                e_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= e_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_strobe) begin
            r_kind  <= e_kind;
            r_obyte <= e_byte;
            r_obits <= (op == shbe_pkg::OP_ENC_BIT) ? n_bits : r_bits;
            r_odist <= r_total;
            r_osym  <= e_sym;
            r_olen  <= e_len;
            r_ocode <= e_code;
            r_oval  <= e_val;
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_total   <= 9'd0;
            r_pack    <= 8'd0;
            r_fill    <= 3'd0;
            r_bits    <= 26'd0;
            r_nocodes <= 1'b0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
        end else begin
            r_p1 <= (op == shbe_pkg::OP_SCAN) && (r_s < r_total);
            r_p2 <= r_p1 && (act_rd != shbe_pkg::NO_NODE);
            case (op)
                shbe_pkg::OP_IDLE: begin
                    if (i_ctl.accept) begin
                        r_byte <= i_data_byte;
                        r_si   <= i_slot_index;
                        if (shbe_pkg::t_cmd'(i_command) == shbe_pkg::CMD_BUILD) begin
                            r_s       <= 9'd0;
                            r_k       <= 9'd0;
                            r_live    <= r_total;
                            r_root    <= 10'd0;
                            r_nocodes <= 1'b0;
                            r_f1      <= 1'b0;
                            r_f2      <= 1'b0;
                        end
                    end
                end
                shbe_pkg::OP_TALLY_LOOK: begin
                    r_slot <= sos_rd;
                    if (new_sym) begin
                        r_vld[r_byte] <= 1'b1;
                        r_total       <= r_total + 9'd1;
                    end
                end
                shbe_pkg::OP_ENC_LOAD: begin
                    r_rem  <= read_len;
                    r_code <= code_rd;
                end
                shbe_pkg::OP_ENC_BIT: begin
                    r_rem  <= rem_m1;
                    r_bits <= n_bits;
                    if (r_fill == 3'd7) begin
                        r_pack <= 8'd0;
                        r_fill <= 3'd0;
                    end else begin
                        r_pack <= pack_or;
                        r_fill <= r_fill + 3'd1;
                    end
                end
                shbe_pkg::OP_FLUSH_TOTAL: begin
                    r_pack <= 8'd0;
                    r_fill <= 3'd0;
                end
                shbe_pkg::OP_CLEAR: begin
                    r_vld     <= '0;
                    r_total   <= 9'd0;
                    r_pack    <= 8'd0;
                    r_fill    <= 3'd0;
                    r_bits    <= 26'd0;
                    r_nocodes <= 1'b0;
                end
                shbe_pkg::OP_INIT: begin
                    r_s  <= o_sts.init_end ? 9'd0 : r_s + 9'd1;
                    r_f1 <= 1'b0;
                    r_f2 <= 1'b0;
                end
                shbe_pkg::OP_SCAN: begin
                    if (r_s < r_total) begin
                        r_s  <= r_s + 9'd1;
                        r_s1 <= r_s[SLOT_AW-1:0];
                    end
                    if (r_p1) begin
                        r_s2  <= r_s1;
                        r_nd2 <= act_rd;
                    end
                    if (r_p2) begin
                        if (!r_f1 || wt_rd < r_w1) begin
                            r_w2 <= r_w1;
                            r_b  <= r_a;
                            r_nb <= r_na;
                            r_f2 <= r_f1;
                            r_w1 <= wt_rd;
                            r_a  <= r_s2;
                            r_na <= r_nd2;
                            r_f1 <= 1'b1;
                        end else if (!r_f2 || wt_rd < r_w2) begin
                            r_w2 <= wt_rd;
                            r_b  <= r_s2;
                            r_nb <= r_nd2;
                            r_f2 <= 1'b1;
                        end
                    end
                end
                shbe_pkg::OP_MERGE2: begin
                    r_k    <= r_k + 9'd1;
                    r_live <= r_live - 9'd1;
                    r_root <= nn;
                    r_s    <= 9'd0;
                    r_f1   <= 1'b0;
                    r_f2   <= 1'b0;
                end
                shbe_pkg::OP_CODE_START: begin
                    r_nd  <= 10'(r_s);
                    r_len <= 6'd0;
                    r_cw  <= 32'd0;
                end
                shbe_pkg::OP_CODE_STEP: begin
                    if (o_sts.len_over) begin
                        r_nocodes <= 1'b1;
                    end
                end
                shbe_pkg::OP_CODE_PAR: begin
                    if (r_len < 6'd32) begin
                        r_cw[r_len[4:0]] <= par_rd[0];
                    end
                    r_len <= r_len + 6'd1;
                    r_nd  <= {1'b0, par_rd[9:1]};
                end
                shbe_pkg::OP_CODE_WRITE: begin
                    r_s <= r_s + 9'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe           = r_strobe;
    assign o_result_kind      = r_kind;
    assign o_out_byte         = r_obyte;
    assign o_total_bits       = r_obits;
    assign o_distinct_symbols = r_odist;
    assign o_symbol           = r_osym;
    assign o_code_nbits       = r_olen;
    assign o_code_bits        = r_ocode;
    assign o_entry_valid      = r_oval;
    assign o_last             = r_olast;

endmodule

// ===== design/static_huffman_byte_encoder.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Fields
// command   in         start high, busy low      i_command, i_data_byte, i_slot_index
// result    out        o_strobe, one cycle       o_result_kind ... o_last
//
// Encode emits nothing for an unseen byte or a byte without a code; otherwise the
// packer shifts in one code bit a cycle.
// Build rescans the slot list through the weight memory for each merge, and reads
// each code by walking parent pointers one level per CODE_STEP and CODE_PAR pair.
// Reset is synchronous and needs no clearing pass. Results are registered, so they
// come out in the cycle after they are made and cannot be held off by the receiver.

module static_huffman_byte_encoder #(
    parameter int SYMBOLS = shbe_pkg::SYMBOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_slot_index,
    output logic        o_strobe,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic [25:0] o_total_bits,
    output logic [8:0]  o_distinct_symbols,
    output logic [7:0]  o_symbol,
    output logic [5:0]  o_code_nbits,
    output logic [31:0] o_code_bits,
    output logic        o_entry_valid,
    output logic        o_last
);

    shbe_pkg::t_ctl ctl;
    shbe_pkg::t_sts sts;

    shbe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_busy    (busy)
    );

    shbe_dp #(.SYMBOLS(SYMBOLS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_command          (i_command),
        .i_data_byte        (i_data_byte),
        .i_slot_index       (i_slot_index),
        .o_strobe           (o_strobe),
        .o_result_kind      (o_result_kind),
        .o_out_byte         (o_out_byte),
        .o_total_bits       (o_total_bits),
        .o_distinct_symbols (o_distinct_symbols),
        .o_symbol           (o_symbol),
        .o_code_nbits       (o_code_nbits),
        .o_code_bits        (o_code_bits),
        .o_entry_valid      (o_entry_valid),
        .o_last             (o_last)
    );

    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without work in progress");

    a_total_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == shbe_pkg::KIND_TOTAL) |-> o_last)
        else $error("bit count result not marked last");

    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == shbe_pkg::KIND_ENTRY && !o_entry_valid)
            |-> (o_code_nbits == 6'd0 && o_code_bits == 32'd0))
        else $error("invalid table entry carries a code");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result transfer directly after a final result");

endmodule

// ===== sim/shbe_checker.sv =====
`timescale 1ns / 1ps

module shbe_checker
    import shbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_slot_index,
    input  logic        i_strobe,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_out_byte,
    input  logic [25:0] i_total_bits,
    input  logic [8:0]  i_distinct_symbols,
    input  logic [7:0]  i_symbol,
    input  logic [5:0]  i_code_nbits,
    input  logic [31:0] i_code_bits,
    input  logic        i_entry_valid,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NSYM = SYMBOLS_DEF;
    localparam int NNODES = 2 * NSYM;
    localparam logic [8:0] NO_SLOT = 9'h1FF;
    localparam logic [27:0] LEAF_MAX = (28'd1 << COUNT_BITS) - 28'd1;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         out_byte;
        logic [BITS_W-1:0]  total_bits;
        logic [TOTAL_W-1:0] distinct;
        logic [7:0]         symbol;
        logic [LEN_W-1:0]   nbits;
        logic [CODE_W-1:0]  code_bits;
        logic               valid;
        logic               last;
    } t_result;

    logic [8:0]          slot_of_byte [256];
    logic [7:0]          byte_of_slot [NSYM];
    logic [WEIGHT_W-1:0] weight [NNODES];
    logic [NODE_W-1:0]   parent [NNODES];
    logic [NODE_W-1:0]   live_node [NSYM];
    logic [LEN_W-1:0]    code_nbits [NSYM];
    logic [CODE_W-1:0]   code_word [NSYM];
    logic [TOTAL_W-1:0]  slots_used;
    logic [7:0]          packer_byte;
    int                  packer_fill;
    logic [BITS_W-1:0]   bits_sent;

    t_result expected_results[$];
    int      mismatches;

    assign o_fail_count = mismatches;

    task automatic clear_encoder();
        for (int i = 0; i < 256; i++) begin
            slot_of_byte[i] = NO_SLOT;
        end
        for (int i = 0; i < NSYM; i++) begin
            live_node[i] = NO_NODE;
            byte_of_slot[i] = '0;
            code_nbits[i] = '0;
            code_word[i] = '0;
        end
        for (int i = 0; i < NNODES; i++) begin
            weight[i] = '0;
            parent[i] = '0;
        end
        slots_used = '0;
        packer_byte = '0;
        packer_fill = 0;
        bits_sent = '0;
    endtask

    task automatic push_result(t_kind kind, logic [7:0] pbyte, logic [7:0] sym,
                               logic [LEN_W-1:0] len, logic [CODE_W-1:0] code,
                               logic valid);
        t_result r;
        r.kind = kind;
        r.out_byte = pbyte;
        r.total_bits = bits_sent;
        r.distinct = slots_used;
        r.symbol = sym;
        r.nbits = len;
        r.code_bits = code;
        r.valid = valid;
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic tally_byte(logic [7:0] b);
        logic [8:0] s;
        s = slot_of_byte[b];
        if (s == NO_SLOT) begin
            if (slots_used < NSYM) begin
                s = slots_used;
                slots_used = slots_used + 1'b1;
                slot_of_byte[b] = s;
                byte_of_slot[s] = b;
                weight[s] = 28'd1;
                code_nbits[s] = '0;
                code_word[s] = '0;
            end
        end else if (weight[s] < LEAF_MAX) begin
            weight[s] = weight[s] + 1'b1;
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] WEIGHT_WIDTH_CAST(longint v);
        return v[WEIGHT_W-1:0];
    endfunction

    task automatic build_codes();
        int n, live, k, a, b, nn, root, nd, len;
        longint w1, w2, sum;
        logic [CODE_W-1:0] code;
        logic overflow;
        n = slots_used;
        overflow = 1'b0;
        for (int s = 0; s < NSYM; s++) begin
            live_node[s] = (s < n) ? NODE_W'(s) : NO_NODE;
            code_nbits[s] = '0;
            code_word[s] = '0;
        end
        if (n != 0) begin
            live = n;
            k = 0;
            while (live > 1) begin
                w1 = 64'hFFFF_FFFF;
                w2 = 64'hFFFF_FFFF;
                a = -1;
                b = -1;
                for (int s = 0; s < n; s++) begin
                    if (live_node[s] != NO_NODE) begin
                        if (weight[live_node[s]] < w1) begin
                            w2 = w1;
                            b = a;
                            w1 = weight[live_node[s]];
                            a = s;
                        end else if (weight[live_node[s]] < w2) begin
                            w2 = weight[live_node[s]];
                            b = s;
                        end
                    end
                end
                nn = NSYM + k;
                sum = longint'(weight[live_node[a]]) + longint'(weight[live_node[b]]);
                weight[nn] = (sum > WEIGHT_MAX) ? WEIGHT_MAX : WEIGHT_WIDTH_CAST(sum);
                parent[live_node[a]] = NODE_W'(nn << 1);
                parent[live_node[b]] = NODE_W'((nn << 1) | 1);
                live_node[a] = NODE_W'(nn);
                live_node[b] = NO_NODE;
                k++;
                live--;
            end
            root = NO_NODE;
            for (int s = n - 1; s >= 0; s--) begin
                if (live_node[s] != NO_NODE) begin
                    root = live_node[s];
                end
            end
            for (int s = 0; s < n && !overflow; s++) begin
                nd = s;
                len = 0;
                code = '0;
                while (nd != root && nd < NNODES && len <= MAX_CODE_LEN) begin
                    if (len < CODE_W) begin
                        code[len] = parent[nd][0];
                    end
                    len++;
                    nd = parent[nd] >> 1;
                end
                if (len > MAX_CODE_LEN) begin
                    overflow = 1'b1;
                end else begin
                    code_nbits[s] = LEN_W'(len);
                    code_word[s] = code;
                end
            end
            if (overflow) begin
                for (int s = 0; s < NSYM; s++) begin
                    code_nbits[s] = '0;
                    code_word[s] = '0;
                end
            end
        end
    endtask

    task automatic encode_byte(logic [7:0] b);
        logic [8:0] s;
        s = slot_of_byte[b];
        if (s != NO_SLOT) begin
            for (int i = code_nbits[s]; i > 0; i--) begin
                packer_byte[7 - packer_fill] = code_word[s][i - 1];
                packer_fill++;
                if (bits_sent < BITS_MAX) begin
                    bits_sent = bits_sent + 1'b1;
                end
                if (packer_fill == 8) begin
                    push_result(KIND_BYTE, packer_byte, '0, '0, '0, 1'b0);
                    packer_byte = '0;
                    packer_fill = 0;
                end
            end
        end
    endtask

    task automatic predict_command(logic [2:0] cmd, logic [7:0] b, logic [7:0] si);
        int before_count;
        before_count = expected_results.size();
        case (cmd)
            CMD_TALLY: tally_byte(b);
            CMD_BUILD: begin
                build_codes();
                push_result(KIND_BUILD, '0, '0, '0, '0, 1'b0);
            end
            CMD_ENCODE: encode_byte(b);
            CMD_FLUSH: begin
                if (packer_fill != 0) begin
                    push_result(KIND_BYTE, packer_byte, '0, '0, '0, 1'b0);
                end
                packer_byte = '0;
                packer_fill = 0;
                push_result(KIND_TOTAL, '0, '0, '0, '0, 1'b0);
            end
            CMD_READ: begin
                if (si < slots_used) begin
                    push_result(KIND_ENTRY, '0, byte_of_slot[si], code_nbits[si],
                                (code_nbits[si] != 0) ? code_word[si] : '0, 1'b1);
                end else begin
                    push_result(KIND_ENTRY, '0, '0, '0, '0, 1'b0);
                end
            end
            CMD_CLEAR: clear_encoder();
            default: ;
        endcase
        if (expected_results.size() > before_count) begin
            expected_results[$].last = 1'b1;
        end
    endtask

    task automatic report(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_result e;
        if (expected_results.size() == 0) begin
            report("unexpected result kind", i_result_kind, 0);
        end else begin
            e = expected_results.pop_front();
            if (i_result_kind != e.kind) report("result_kind", i_result_kind, e.kind);
            if (i_out_byte != e.out_byte) report("out_byte", i_out_byte, e.out_byte);
            if (i_total_bits != e.total_bits) report("total_bits", i_total_bits, e.total_bits);
            if (i_distinct_symbols != e.distinct) begin
                report("distinct_symbols", i_distinct_symbols, e.distinct);
            end
            if (i_symbol != e.symbol) report("symbol", i_symbol, e.symbol);
            if (i_code_nbits != e.nbits) report("code_nbits", i_code_nbits, e.nbits);
            if (i_code_bits != e.code_bits) report("code_bits", i_code_bits, e.code_bits);
            if (i_entry_valid != e.valid) report("entry_valid", i_entry_valid, e.valid);
            if (i_last != e.last) report("last", i_last, e.last);
        end
    endtask

    initial begin
        mismatches = 0;
        o_pending = 0;
        clear_encoder();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_encoder();
            expected_results.delete();
        end else begin
            if (i_strobe) begin
                check_result();
            end
            if (i_start && !i_busy) begin
                predict_command(i_command, i_data_byte, i_slot_index);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import shbe_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int IDLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_data_byte = '0;
    logic [7:0]  i_slot_index = '0;
    logic        o_strobe;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_out_byte;
    logic [25:0] o_total_bits;
    logic [8:0]  o_distinct_symbols;
    logic [7:0]  o_symbol;
    logic [5:0]  o_code_nbits;
    logic [31:0] o_code_bits;
    logic        o_entry_valid;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [7:0]  alphabet[$];

    always #1 i_clk = ~i_clk;

    static_huffman_byte_encoder i_dut (.*);

    shbe_checker i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_command, .i_data_byte,
        .i_slot_index, .i_strobe(o_strobe), .i_result_kind(o_result_kind),
        .i_out_byte(o_out_byte), .i_total_bits(o_total_bits),
        .i_distinct_symbols(o_distinct_symbols), .i_symbol(o_symbol),
        .i_code_nbits(o_code_nbits), .i_code_bits(o_code_bits),
        .i_entry_valid(o_entry_valid), .i_last(o_last), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(logic [2:0] cmd, logic [7:0] b, logic [7:0] si);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_command <= cmd;
        i_data_byte <= b;
        i_slot_index <= si;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        int a;
        a = $urandom_range(0, alphabet.size() - 1);
        a = (a < $urandom_range(0, alphabet.size() - 1)) ? a : $urandom_range(0, a);
        return alphabet[a];
    endfunction

    initial begin
        int nsym, ntally;
        logic [7:0] b;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(CMD_READ, 8'h00, 8'h00);
        send(CMD_BUILD, 8'h00, 8'hFF);
        send(CMD_FLUSH, 8'h00, 8'h00);
        send(CMD_ENCODE, 8'h00, 8'h00);
        send(CMD_TALLY, 8'hFF, 8'h00);
        send(CMD_BUILD, 8'h00, 8'h00);
        send(CMD_ENCODE, 8'hFF, 8'h00);
        send(CMD_READ, 8'h00, 8'h00);
        send(CMD_TALLY, 8'h00, 8'h00);
        send(CMD_TALLY, 8'h00, 8'h00);
        send(CMD_TALLY, 8'hA5, 8'h00);
        send(CMD_TALLY, 8'h5A, 8'h00);
        send(CMD_BUILD, 8'h00, 8'h00);
        send(CMD_ENCODE, 8'h00, 8'h00);
        send(CMD_ENCODE, 8'hA5, 8'h00);
        send(CMD_ENCODE, 8'h33, 8'h00);
        send(CMD_FLUSH, 8'h00, 8'h00);
        send(CMD_TALLY, 8'h33, 8'h00);
        send(CMD_READ, 8'h00, 8'h04);
        send(CMD_ENCODE, 8'h33, 8'h00);
        send(CMD_READ, 8'h00, 8'h02);
        send(CMD_READ, 8'h00, 8'hFF);
        send(CMD_SPARE6, 8'hFF, 8'hFF);
        send(CMD_SPARE7, 8'h00, 8'h00);
        send(CMD_CLEAR, 8'h00, 8'h00);
        send(CMD_FLUSH, 8'h00, 8'h00);
        drain();

        // Full table: every byte value once, then a skewed tail of repeats.
        for (int i = 0; i < 256; i++) send(CMD_TALLY, 8'(i), 8'($urandom));
        repeat (40) send(CMD_TALLY, 8'($urandom_range(0, 15)), 8'($urandom));
        send(CMD_BUILD, 8'($urandom), 8'($urandom));
        repeat (6) send(CMD_READ, 8'($urandom), 8'($urandom));
        repeat (30) send(CMD_ENCODE, 8'($urandom), 8'($urandom));
        send(CMD_FLUSH, 8'($urandom), 8'($urandom));
        send(CMD_CLEAR, 8'($urandom), 8'($urandom));

        for (int sess = 0; sess < 5; sess++) begin
            alphabet.delete();
            nsym = $urandom_range(1, 12);
            repeat (nsym) alphabet.push_back(8'($urandom));
            ntally = $urandom_range(nsym, 25);
            for (int i = 0; i < ntally; i++) send(CMD_TALLY, pick_symbol(), 8'($urandom));
            send(CMD_BUILD, 8'($urandom), 8'($urandom));
            repeat (3) send(CMD_READ, 8'($urandom), 8'($urandom_range(0, 13)));
            repeat ($urandom_range(5, 20)) begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_symbol();
                send(CMD_ENCODE, b, 8'($urandom));
                if ($urandom_range(0, 15) == 0) begin
                    send(3'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            send(CMD_FLUSH, 8'($urandom), 8'($urandom));
            if (sess == 2) drain();
            if ($urandom_range(0, 1) == 0) send(CMD_CLEAR, 8'($urandom), 8'($urandom));
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/shbe_pkg.sv
design/shbe_ram.sv
design/shbe_ctrl.sv
design/shbe_dp.sv
design/static_huffman_byte_encoder.sv
sim/shbe_checker.sv
sim/tb_top.sv
